>>> src/lfsa_pkg.sv
package lfsa_pkg;

  localparam int NUM_SLOTS = 64;
  localparam int SLOT_W    = $clog2(NUM_SLOTS);
  localparam int OUT_IDX_W = 6;
  localparam int IDX_W     = (SLOT_W > OUT_IDX_W) ? SLOT_W : OUT_IDX_W;
  localparam int TIME_W    = 32;

  typedef struct packed {
    logic [OUT_IDX_W-1:0] slot_index;
    logic                 is_target;
    logic                 no_slot;
  } lfsa_res_t;

  typedef struct packed {
    logic              rd_en;
    logic [SLOT_W-1:0] rd_addr;
    logic              wr_en;
    logic [SLOT_W-1:0] wr_addr;
    logic [TIME_W-1:0] wr_data;
  } lfsa_ram_req_t;

endpackage

>>> src/lfsa_ifs.sv
interface lfsa_req_if;
  import lfsa_pkg::*;

  logic              valid;
  logic              ready;
  logic [TIME_W-1:0] arrival_time;
  logic [TIME_W-1:0] release_time;

  modport source (output valid, output arrival_time, output release_time, input ready);
  modport sink (input valid, input arrival_time, input release_time, output ready);
endinterface

interface lfsa_rsp_if;
  import lfsa_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [OUT_IDX_W-1:0] slot_index;
  logic                 is_target;
  logic                 no_slot;

  modport source (output valid, output slot_index, output is_target, output no_slot,
                  input ready);
  modport sink (input valid, input slot_index, input is_target, input no_slot,
                output ready);
endinterface

>>> src/lowest_free_slot_timed_allocator.sv
// channel  | dir | payload                              | handshake
// req      | in  | arrival_time[31:0] release_time[31:0] | valid/ready
// rsp      | out | slot_index[5:0] is_target no_slot     | valid/ready
// cfg      | in  | cfg_wdata[31:0] (target_arrival)      | cfg_we, no ready
//
// one word in flight: its slots are compared from slot 0 upward, one slot a cycle, as set
// by the single read port of the slot memory, until a free slot is found or all NUM_SLOTS are
// compared; the result is then offered from hold and the next word is taken after it leaves hold
// reset clears all slot free times at once through per-slot written flags, no sweep
// a finished result waits in the output register; the next word is taken meanwhile
// and its scan stalls in hold only if the output register is still full
module lowest_free_slot_timed_allocator (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [lfsa_pkg::TIME_W-1:0] cfg_wdata,
  lfsa_req_if.sink                    req,
  lfsa_rsp_if.source                  rsp
);
  import lfsa_pkg::*;

  logic [TIME_W-1:0] target;
  lfsa_ram_req_t     ram_req;
  logic [TIME_W-1:0] ram_rd_data;
  logic              res_valid;
  logic              res_ready;
  lfsa_res_t         res;
  logic              out_valid;
  lfsa_res_t         out_word;

  always_ff @(posedge clk) begin
    if (rst) begin
      target <= '0;
    end else if (cfg_we) begin
      target <= cfg_wdata;
    end
  end

  lfsa_slot_ram u_ram (
    .clk     (clk),
    .rst     (rst),
    .ram_req (ram_req),
    .rd_data (ram_rd_data)
  );

  lfsa_scan u_scan (
    .clk         (clk),
    .rst         (rst),
    .target      (target),
    .req         (req),
    .ram_req     (ram_req),
    .ram_rd_data (ram_rd_data),
    .res_valid   (res_valid),
    .res         (res),
    .res_ready   (res_ready)
  );

  assign res_ready = !out_valid || rsp.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_word <= res;
    end
  end

  assign rsp.valid      = out_valid;
  assign rsp.slot_index = out_word.slot_index;
  assign rsp.is_target  = out_word.is_target;
  assign rsp.no_slot    = out_word.no_slot;

endmodule

>>> src/lfsa_slot_ram.sv
module lfsa_slot_ram (
  input  logic                           clk,
  input  logic                           rst,
  input  lfsa_pkg::lfsa_ram_req_t        ram_req,
  output logic [lfsa_pkg::TIME_W-1:0]    rd_data
);
  import lfsa_pkg::*;

  logic [TIME_W-1:0]    mem [NUM_SLOTS];
  logic [NUM_SLOTS-1:0] written;
  logic [TIME_W-1:0]    rd_q;
  logic                 rd_written;

  always_ff @(posedge clk) begin
    if (ram_req.wr_en) begin
      mem[ram_req.wr_addr] <= ram_req.wr_data;
    end
    if (ram_req.rd_en) begin
      rd_q <= mem[ram_req.rd_addr];
    end
  end

  // a slot never written since reset reads as free at time zero
  always_ff @(posedge clk) begin
    if (rst) begin
      written    <= '0;
      rd_written <= 1'b0;
    end else begin
      if (ram_req.wr_en) begin
        written[ram_req.wr_addr] <= 1'b1;
      end
      if (ram_req.rd_en) begin
        rd_written <= written[ram_req.rd_addr];
      end
    end
  end

  assign rd_data = rd_written ? rd_q : '0;

endmodule

>>> src/lfsa_scan.sv
module lfsa_scan (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [lfsa_pkg::TIME_W-1:0] target,
  lfsa_req_if.sink                    req,
  output lfsa_pkg::lfsa_ram_req_t     ram_req,
  input  logic [lfsa_pkg::TIME_W-1:0] ram_rd_data,
  output logic                        res_valid,
  output lfsa_pkg::lfsa_res_t         res,
  input  logic                        res_ready
);
  import lfsa_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_HOLD = 2'd2;

  logic [1:0]        state;
  logic [TIME_W-1:0] arrive;
  logic [TIME_W-1:0] leave;
  logic [SLOT_W-1:0] chk_idx;
  logic [IDX_W-1:0]  pick_ext;
  logic              accept;
  logic              slot_free;
  logic              last;
  logic              scanning;

  assign req.ready = (state == ST_IDLE);
  assign accept    = req.valid && req.ready;
  assign scanning  = (state == ST_SCAN);
  assign slot_free = (ram_rd_data <= arrive);
  assign last      = (chk_idx == SLOT_W'(NUM_SLOTS - 1));
  assign pick_ext  = IDX_W'(chk_idx);
  assign res_valid = (state == ST_HOLD);

  // read data in SCAN belongs to chk_idx; next read goes out only while still searching
  always_comb begin
    ram_req.rd_en   = accept || (scanning && !slot_free && !last);
    ram_req.rd_addr = accept ? '0 : chk_idx + SLOT_W'(1);
    ram_req.wr_en   = scanning && slot_free;
    ram_req.wr_addr = chk_idx;
    ram_req.wr_data = leave;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      chk_idx <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (accept) begin
            chk_idx <= '0;
            state   <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (slot_free || last) begin
            state <= ST_HOLD;
          end else begin
            chk_idx <= chk_idx + SLOT_W'(1);
          end
        end
        ST_HOLD: begin
          if (res_ready) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      arrive        <= req.arrival_time;
      leave         <= req.release_time;
      res.is_target <= (req.arrival_time == target);
    end
    if (scanning && slot_free) begin
      res.slot_index <= pick_ext[OUT_IDX_W-1:0];
      res.no_slot    <= 1'b0;
    end else if (scanning && last) begin
      res.slot_index <= '0;
      res.no_slot    <= 1'b1;
    end
  end

  a_write_ends_scan: assert property (@(posedge clk) disable iff (rst)
    ram_req.wr_en |=> (state == ST_HOLD))
    else $error("slot write did not end the scan");

  a_one_write: assert property (@(posedge clk) disable iff (rst)
    ram_req.wr_en |=> !ram_req.wr_en)
    else $error("more than one slot written for a word");

  a_no_slot_zero: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res.no_slot) |-> (res.slot_index == '0))
    else $error("no_slot result carries a nonzero index");

  a_scan_starts_low: assert property (@(posedge clk) disable iff (rst)
    accept |=> (scanning && (chk_idx == '0)))
    else $error("scan did not start at slot zero");

  a_full_scan_no_write: assert property (@(posedge clk) disable iff (rst)
    (scanning && last && !slot_free) |=> (res_valid && res.no_slot))
    else $error("exhausted scan did not report no_slot");

endmodule

>>> test/tb_lowest_free_slot_timed_allocator.sv
module tb_lowest_free_slot_timed_allocator;
  import lfsa_pkg::*;

  localparam int CYCLE_LIMIT  = 2000000;
  localparam int DRAIN_CYCLES = 100;
  localparam int SETTLE_CYCLES = NUM_SLOTS + 8;
  localparam int HOLD_AFTER   = 700;
  localparam int HOLD_CYCLES  = 3000;
  localparam int MAX_REPORTS  = 10;

  typedef struct packed {
    logic [TIME_W-1:0] arrive_at;
    logic [TIME_W-1:0] leave_at;
  } alloc_req_t;

  logic              clk = 1'b0;
  logic              rst;
  logic              cfg_we;
  logic [TIME_W-1:0] cfg_wdata;
  logic              rx_hold;

  lfsa_req_if req_ch ();
  lfsa_rsp_if rsp_ch ();

  lowest_free_slot_timed_allocator u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .req       (req_ch),
    .rsp       (rsp_ch)
  );

  // shadow of the slot table and the target register
  logic [TIME_W-1:0] free_time [NUM_SLOTS];
  logic [TIME_W-1:0] target_arr;

  alloc_req_t pending_reqs [$];
  alloc_req_t batch [$];
  lfsa_res_t  expected_grants [$];

  alloc_req_t next_req;
  lfsa_res_t  want;
  int         n_accepted = 0;
  int         fail_cnt = 0;
  int         cycle_cnt = 0;
  int         burst_left = 1;
  int         gap_left = 0;
  int         ready_mode = 0;
  int         mode_left = 0;
  logic       go_ready;

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  function automatic lfsa_res_t grant_slot(logic [TIME_W-1:0] arr, logic [TIME_W-1:0] lv);
    lfsa_res_t r;
    int        pick;
    int        i;
    pick = -1;
    for (i = 0; i < NUM_SLOTS; i++) begin
      if (pick < 0 && free_time[i] <= arr) pick = i;
    end
    r.is_target = (arr == target_arr);
    if (pick < 0) begin
      r.slot_index = '0;
      r.no_slot    = 1'b1;
    end else begin
      free_time[pick] = lv;
      r.slot_index    = pick[OUT_IDX_W-1:0];
      r.no_slot       = 1'b0;
    end
    return r;
  endfunction

  // sender: bursts of random length with random gaps
  always @(posedge clk) begin
    if (rst) begin
      req_ch.valid <= 1'b0;
    end else begin
      if (req_ch.valid && req_ch.ready) begin
        expected_grants.push_back(grant_slot(req_ch.arrival_time, req_ch.release_time));
        n_accepted++;
      end
      if (req_ch.valid && !req_ch.ready) begin
        // word still offered, keep it
      end else if (gap_left > 0) begin
        gap_left--;
        req_ch.valid <= 1'b0;
      end else if (pending_reqs.size() > 0) begin
        next_req = pending_reqs.pop_front();
        req_ch.valid        <= 1'b1;
        req_ch.arrival_time <= next_req.arrive_at;
        req_ch.release_time <= next_req.leave_at;
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 30);
          gap_left   = $urandom_range(0, 1) ? 0 : $urandom_range(1, 80);
        end
      end else begin
        req_ch.valid <= 1'b0;
      end
    end
  end

  // receiver: checks results and stalls on its own pattern
  always @(posedge clk) begin
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (expected_grants.size() == 0) begin
        fail_cnt++;
        if (fail_cnt <= MAX_REPORTS)
          $display("unexpected result: slot %0d target %0b none %0b",
                   rsp_ch.slot_index, rsp_ch.is_target, rsp_ch.no_slot);
      end else begin
        want = expected_grants.pop_front();
        if (rsp_ch.slot_index !== want.slot_index || rsp_ch.is_target !== want.is_target ||
            rsp_ch.no_slot !== want.no_slot) begin
          fail_cnt++;
          if (fail_cnt <= MAX_REPORTS)
            $display("mismatch: exp slot %0d tgt %0b none %0b, got slot %0d tgt %0b none %0b",
                     want.slot_index, want.is_target, want.no_slot,
                     rsp_ch.slot_index, rsp_ch.is_target, rsp_ch.no_slot);
        end
      end
    end
    if (mode_left == 0) begin
      ready_mode = $urandom_range(0, 4);
      mode_left  = $urandom_range(20, 300);
    end else begin
      mode_left--;
    end
    case (ready_mode)
      0: begin
        go_ready = 1'b1;
      end
      1: begin
        go_ready = $urandom_range(0, 1);
      end
      2: begin
        go_ready = ($urandom_range(0, 9) != 0);
      end
      3: begin
        go_ready = ((mode_left % 4) != 0);
      end
      default: begin
        go_ready = ($urandom_range(0, 4) == 0);
      end
    endcase
    rsp_ch.ready <= !rst && !rx_hold && go_ready;
  end

  // long receiver hold-off so the block backs up into its input
  initial begin
    rx_hold = 1'b0;
    while (n_accepted < HOLD_AFTER) @(posedge clk);
    rx_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    rx_hold <= 1'b0;
  end

  task automatic add_req(logic [TIME_W-1:0] arr, logic [TIME_W-1:0] lv);
    alloc_req_t r;
    r.arrive_at = arr;
    r.leave_at  = lv;
    pending_reqs.push_back(r);
  endtask

  task automatic wait_drained();
    while (pending_reqs.size() != 0 || expected_grants.size() != 0 || req_ch.valid)
      @(posedge clk);
  endtask

  task automatic set_target(logic [TIME_W-1:0] value);
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we     <= 1'b1;
    cfg_wdata  <= value;
    target_arr = value;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // mostly ordered traffic around a running clock, with fill bursts and noise
  task automatic build_batch(int n, logic [TIME_W-1:0] base);
    logic [TIME_W-1:0] now;
    alloc_req_t        r;
    int                sel;
    int                cnt;
    now = base;
    batch.delete();
    while (batch.size() < n) begin
      sel = $urandom_range(0, 99);
      if (sel < 4) begin
        r.arrive_at = $urandom;
        r.leave_at  = r.arrive_at + $urandom_range(0, 50);
        batch.push_back(r);
      end else if (sel < 7) begin
        // NUM_SLOTS - 4 to NUM_SLOTS + 6 words at one arrival, often enough to run out of slots
        cnt = $urandom_range(NUM_SLOTS - 4, NUM_SLOTS + 6);
        repeat (cnt) begin
          r.arrive_at = now;
          r.leave_at  = now + $urandom_range(20, 200);
          batch.push_back(r);
        end
      end else begin
        now = now + (($urandom_range(0, 19) == 0) ? $urandom_range(0, 400)
                                                  : $urandom_range(0, 6));
        r.arrive_at = now;
        sel = $urandom_range(0, 199);
        if (sel < 15) r.leave_at = now - $urandom_range(0, 5);
        else if (sel == 15) r.leave_at = $urandom;
        else r.leave_at = now + $urandom_range(1, 120);
        batch.push_back(r);
      end
    end
  endtask

  task automatic run_batch(int n, logic [TIME_W-1:0] base);
    build_batch(n, base);
    set_target(batch[$urandom_range(0, batch.size() - 1)].arrive_at);
    foreach (batch[i]) pending_reqs.push_back(batch[i]);
  endtask

  initial begin
    rst                 = 1'b1;
    cfg_we              = 1'b0;
    cfg_wdata           = '0;
    req_ch.valid        = 1'b0;
    req_ch.arrival_time = '0;
    req_ch.release_time = '0;
    rsp_ch.ready        = 1'b0;
    target_arr          = '0;
    foreach (free_time[i]) free_time[i] = '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    set_target('0);
    add_req(32'd0, 32'd0);
    add_req(32'd0, 32'hFFFF_FFFF);
    add_req(32'd0, 32'd5);
    add_req(32'd3, 32'd1);   // release before arrival
    add_req(32'd2, 32'd10);  // arrival out of order
    add_req(32'd5, 32'd7);

    set_target(32'hFFFF_FFFF);
    add_req(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    add_req(32'hFFFF_FFFF, 32'd0);
    add_req(32'h8000_0000, 32'h7FFF_FFFF);
    add_req(32'hAAAA_AAAA, 32'h5555_5555);
    add_req(32'h5555_5555, 32'hAAAA_AAAA);

    // every slot taken, then one more just before those slots free up
    set_target(32'd1000);
    repeat (NUM_SLOTS + 3) add_req(32'd1000, 32'd1900);
    add_req(32'd1899, 32'd5);

    run_batch(500, 32'd2000);
    run_batch(400, 32'h7FFF_0000);
    run_batch(250, 32'hC000_0000);
    run_batch(220, 32'hFFFF_FC00);

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_cnt == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
